// ===== design/sat_pkg.sv =====
// Shared types and constants of the summed-area table stream.
`timescale 1ns / 1ps

package sat_pkg;

    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 2;
    localparam int PLANE_W     = 2;
    localparam int PLANE_CNT_W = 3;

    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PLANE_COUNT  = 2'd2;

    localparam logic [CFG_DATA_W-1:0]  FRAME_WIDTH_RESET  = 11'd1024;
    localparam logic [CFG_DATA_W-1:0]  FRAME_HEIGHT_RESET = 11'd1024;
    localparam logic [PLANE_CNT_W-1:0] PLANE_COUNT_RESET  = 3'd1;
    localparam logic [PLANE_CNT_W-1:0] MAX_PLANES         = 3'd4;

    typedef struct packed {
        logic row_end;
        logic plane_end;
        logic image_end;
    } t_flags;

    localparam int FLAGS_W = $bits(t_flags);

endpackage

// ===== design/summed_area_table_stream.sv =====
// Top level of the streaming summed-area table.
`timescale 1ns / 1ps

// Pixels enter in raster order, one word per clock while the middle queue is
// not full, and each yields one word holding the inclusive upper-left sum of
// its plane with row, plane and image end marks. Throughput is one word per
// cycle while neither queue is full. A word passes the middle queue and then
// the sum stage, which adds the registered read of the line store holding the
// previous row's sums, before it reaches the result queue to be popped. The
// line store needs no clearing pass after reset, since the first row of each
// plane never reads it. Configuration must be written by the user only while
// no word is in flight; the block itself does not enforce this.
module summed_area_table_stream
    import sat_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  logic                                                       i_clk,
    input  logic                                                       i_rst_n,
    input  logic                                                       i_cfg_we,
    input  logic [CFG_INDEX_W-1:0]                                     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]                                      i_cfg_data,
    input  logic                                                       push,
    output logic                                                       full,
    input  logic [PIXEL_BITS-1:0]                                      i_pixel,
    output logic                                                       empty,
    input  logic                                                       pop,
    output logic [PIXEL_BITS+$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT)-1:0] o_area_sum,
    output logic                                                       o_row_end,
    output logic                                                       o_plane_end,
    output logic                                                       o_image_end
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RSW   = PIXEL_BITS + CW;
    localparam int SUM_W = PIXEL_BITS + CW + $clog2(MAX_HEIGHT);
    localparam int MID_W = RSW + CW + 1 + FLAGS_W;
    localparam int OUT_W = SUM_W + FLAGS_W;

    logic             f_push;
    logic [RSW-1:0]   f_rsum;
    logic [CW-1:0]    f_col;
    logic             f_first;
    t_flags           f_flags;

    logic             q_full;
    logic             q_empty;
    logic             q_pop;
    logic [MID_W-1:0] q_data;

    logic [RSW-1:0]   b_rsum;
    logic [CW-1:0]    b_col;
    logic             b_first;
    t_flags           b_flags_in;

    logic             out_push;
    logic             out_full;
    logic [SUM_W-1:0] out_sum;
    t_flags           out_flags;
    logic [OUT_W-1:0] res_data;
    t_flags           res_flags;

    sat_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_push      (push),
        .i_pixel     (i_pixel),
        .i_q_full    (q_full),
        .o_q_push    (f_push),
        .o_rsum      (f_rsum),
        .o_col       (f_col),
        .o_first_row (f_first),
        .o_flags     (f_flags)
    );

    sat_fifo #(
        .WIDTH (MID_W),
        .DEPTH (4)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  ({f_rsum, f_col, f_first, f_flags}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_empty (q_empty)
    );

    assign {b_rsum, b_col, b_first, b_flags_in} = q_data;

    sat_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .o_q_pop     (q_pop),
        .i_rsum      (b_rsum),
        .i_col       (b_col),
        .i_first_row (b_first),
        .i_flags     (b_flags_in),
        .i_out_full  (out_full),
        .o_out_push  (out_push),
        .o_sum       (out_sum),
        .o_flags     (out_flags)
    );

    sat_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (4)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  ({out_sum, out_flags}),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (res_data),
        .o_empty (empty)
    );

    assign full                    = q_full;
    assign {o_area_sum, res_flags} = res_data;
    assign o_row_end               = res_flags.row_end;
    assign o_plane_end             = res_flags.plane_end;
    assign o_image_end             = res_flags.image_end;

endmodule

// ===== design/sat_fifo.sv =====
// Small show-ahead queue used between the stages and at the result side.
`timescale 1ns / 1ps

module sat_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [AW:0]      r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= next_ptr(r_wr);
            end
            if (do_pop) begin
                r_rd <= next_ptr(r_rd);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== design/sat_front.sv =====
// Front stage: configuration, raster counters, row running sum and end flags.
`timescale 1ns / 1ps

module sat_front
    import sat_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [CFG_INDEX_W-1:0]                  i_cfg_index,
    input  logic [CFG_DATA_W-1:0]                   i_cfg_data,
    input  logic                                    i_push,
    input  logic [PIXEL_BITS-1:0]                   i_pixel,
    input  logic                                    i_q_full,
    output logic                                    o_q_push,
    output logic [PIXEL_BITS+$clog2(MAX_WIDTH)-1:0] o_rsum,
    output logic [$clog2(MAX_WIDTH)-1:0]            o_col,
    output logic                                    o_first_row,
    output t_flags                                  o_flags
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int RSW = PIXEL_BITS + CW;

    logic [CFG_DATA_W-1:0]  r_frame_width;
    logic [CFG_DATA_W-1:0]  r_frame_height;
    logic [PLANE_CNT_W-1:0] r_plane_count;
    logic [CW-1:0]          r_col;
    logic [RW-1:0]          r_row;
    logic [PLANE_W-1:0]     r_plane;
    logic [RSW-1:0]         r_rsum;

    logic [CW-1:0]          n_col;
    logic [RW-1:0]          n_row;
    logic [PLANE_W-1:0]     n_plane;
    logic [RSW-1:0]         n_rsum;

    logic [31:0]            w_full;
    logic [31:0]            h_full;
    logic [CW:0]            w_eff;
    logic [RW:0]            h_eff;
    logic [PLANE_CNT_W-1:0] c_eff;
    logic [RSW-1:0]         sum_now;
    logic                   row_end;
    logic                   plane_end;
    logic                   image_end;

    always_comb begin
        if (r_frame_width == '0) begin
            w_full = 32'd1;
        end else if (32'(r_frame_width) > 32'(MAX_WIDTH)) begin
            w_full = 32'(MAX_WIDTH);
        end else begin
            w_full = 32'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            h_full = 32'd1;
        end else if (32'(r_frame_height) > 32'(MAX_HEIGHT)) begin
            h_full = 32'(MAX_HEIGHT);
        end else begin
            h_full = 32'(r_frame_height);
        end
        if (r_plane_count == '0) begin
            c_eff = PLANE_CNT_W'(1);
        end else if (r_plane_count > MAX_PLANES) begin
            c_eff = MAX_PLANES;
        end else begin
            c_eff = r_plane_count;
        end
    end

    assign w_eff     = w_full[CW:0];
    assign h_eff     = h_full[RW:0];
    assign sum_now   = r_rsum + RSW'(i_pixel);
    assign row_end   = ({1'b0, r_col} + 1'b1) >= w_eff;
    assign plane_end = row_end && (({1'b0, r_row} + 1'b1) >= h_eff);
    assign image_end = plane_end &&
                       ((PLANE_CNT_W'(r_plane) + 1'b1) >= c_eff);

    assign o_q_push          = i_push && !i_q_full;
    assign o_rsum            = sum_now;
    assign o_col             = r_col;
    assign o_first_row       = (r_row == '0);
    assign o_flags.row_end   = row_end;
    assign o_flags.plane_end = plane_end;
    assign o_flags.image_end = image_end;

    always_comb begin
        n_col   = r_col + 1'b1;
        n_row   = r_row;
        n_plane = r_plane;
        n_rsum  = sum_now;
        if (row_end) begin
            n_col  = '0;
            n_rsum = '0;
            if (plane_end) begin
                n_row   = '0;
                n_plane = image_end ? '0 : r_plane + 1'b1;
            end else begin
                n_row = r_row + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RESET;
            r_frame_height <= FRAME_HEIGHT_RESET;
            r_plane_count  <= PLANE_COUNT_RESET;
            r_col          <= '0;
            r_row          <= '0;
            r_plane        <= '0;
            r_rsum         <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                    CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                    CFG_PLANE_COUNT:  r_plane_count  <= i_cfg_data[PLANE_CNT_W-1:0];
                    default: ;
                endcase
            end
            if (o_q_push) begin
                r_col   <= n_col;
                r_row   <= n_row;
                r_plane <= n_plane;
                r_rsum  <= n_rsum;
            end
        end
    end

endmodule

// ===== design/sat_back.sv =====
// Back stage: line store lookup, table sum and line store update.
`timescale 1ns / 1ps

module sat_back
    import sat_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  logic                                                       i_clk,
    input  logic                                                       i_rst_n,
    input  logic                                                       i_q_empty,
    output logic                                                       o_q_pop,
    input  logic [PIXEL_BITS+$clog2(MAX_WIDTH)-1:0]                    i_rsum,
    input  logic [$clog2(MAX_WIDTH)-1:0]                               i_col,
    input  logic                                                       i_first_row,
    input  t_flags                                                     i_flags,
    input  logic                                                       i_out_full,
    output logic                                                       o_out_push,
    output logic [PIXEL_BITS+$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT)-1:0] o_sum,
    output t_flags                                                     o_flags
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RSW   = PIXEL_BITS + CW;
    localparam int SUM_W = PIXEL_BITS + CW + $clog2(MAX_HEIGHT);

    logic [SUM_W-1:0] r_line [MAX_WIDTH];
    logic [SUM_W-1:0] r_rd;
    logic [SUM_W-1:0] r_fwd_sum;
    logic             r_fwd;
    logic             r_b_valid;
    logic [RSW-1:0]   r_b_rsum;
    logic [CW-1:0]    r_b_col;
    logic             r_b_first;
    t_flags           r_b_flags;

    logic             b_fire;
    logic [SUM_W-1:0] above;
    logic [SUM_W-1:0] b_sum;

    assign b_fire  = r_b_valid && !i_out_full;
    assign o_q_pop = !i_q_empty && (!r_b_valid || b_fire);
    assign above   = r_b_first ? '0 : (r_fwd ? r_fwd_sum : r_rd);
    assign b_sum   = SUM_W'(r_b_rsum) + above;

    assign o_out_push = b_fire;
    assign o_sum      = b_sum;
    assign o_flags    = r_b_flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_b_valid <= 1'b1;
        end else if (b_fire) begin
            r_b_valid <= 1'b0;
        end
    end

    // A word whose read meets the write of the same column in the same cycle
    // takes the freshly written sum instead of the stale line store data.
    always_ff @(posedge i_clk) begin
        if (b_fire) begin
            r_line[r_b_col] <= b_sum;
        end
        if (o_q_pop) begin
            r_rd      <= r_line[i_col];
            r_fwd     <= b_fire && (r_b_col == i_col);
            r_fwd_sum <= b_sum;
            r_b_rsum  <= i_rsum;
            r_b_col   <= i_col;
            r_b_first <= i_first_row;
            r_b_flags <= i_flags;
        end
    end

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> !i_q_empty)
        else $error("Queue popped while empty.");

    a_pop_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> r_b_valid)
        else $error("Popped word did not reach the sum stage.");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && i_out_full) |=> (r_b_valid && $stable(r_b_col)
                                       && $stable(r_b_rsum)))
        else $error("Stalled sum stage lost its word.");

    a_flag_nesting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> ((!r_b_flags.image_end || r_b_flags.plane_end)
                       && (!r_b_flags.plane_end || r_b_flags.row_end)))
        else $error("End flags are not nested.");

endmodule

// ===== test/tb_summed_area_table_stream.sv =====
// Self-checking testbench of the streaming summed-area table with a built-in predictor.
`timescale 1ns / 1ps

module tb_summed_area_table_stream;
    import sat_pkg::*;

    localparam int PIX_W       = 8;
    localparam int LINE_DEPTH  = 1024;
    localparam int ROWS_MAX    = 1024;
    localparam int SUM_W       = PIX_W + $clog2(LINE_DEPTH) + $clog2(ROWS_MAX);
    localparam int RANDOM_WORDS = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 5000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic [SUM_W-1:0] area_sum;
        t_flags           flags;
    } t_area_word;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = CFG_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   push = 1'b0;
    logic                   full;
    logic [PIX_W-1:0]       i_pixel = '0;
    logic                   empty;
    logic                   pop = 1'b0;
    logic [SUM_W-1:0]       o_area_sum;
    logic                   o_row_end;
    logic                   o_plane_end;
    logic                   o_image_end;

    summed_area_table_stream u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .push        (push),
        .full        (full),
        .i_pixel     (i_pixel),
        .empty       (empty),
        .pop         (pop),
        .o_area_sum  (o_area_sum),
        .o_row_end   (o_row_end),
        .o_plane_end (o_plane_end),
        .o_image_end (o_image_end)
    );

    logic [PIX_W-1:0] pixel_backlog [$];
    t_area_word       area_expect [$];
    int               mismatch_count = 0;
    int               idle_pct = 0;
    int               stall_pct = 0;
    bit               hold_pending = 1'b0;
    bit               hold_taken = 1'b0;
    int               hold_left = 0;
    int               quiet_cycles = 0;

    // Predictor copy of the configuration and of the running state.
    logic [CFG_DATA_W-1:0]  width_reg = FRAME_WIDTH_RESET;
    logic [CFG_DATA_W-1:0]  height_reg = FRAME_HEIGHT_RESET;
    logic [PLANE_CNT_W-1:0] planes_reg = PLANE_COUNT_RESET;
    logic [17:0]            run_sum = '0;
    logic [SUM_W-1:0]       line_sums [LINE_DEPTH];
    bit                     line_valid [LINE_DEPTH];
    logic [9:0]             col_q = '0;
    logic [9:0]             row_q = '0;
    logic [PLANE_W-1:0]     plane_q = '0;

    function automatic int clamp_to(int v, int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic t_area_word integrate_pixel(logic [PIX_W-1:0] pix);
        int               wid;
        int               hgt;
        int               cnt;
        logic [SUM_W-1:0] above;
        logic [SUM_W-1:0] sum;
        t_area_word       word;
        wid = clamp_to(width_reg, LINE_DEPTH);
        hgt = clamp_to(height_reg, ROWS_MAX);
        cnt = clamp_to(planes_reg, MAX_PLANES);
        run_sum = run_sum + pix;
        above = (row_q != 0) ? line_sums[col_q] : '0;
        sum = run_sum + above;
        line_sums[col_q] = sum;
        line_valid[col_q] = 1'b1;
        word.area_sum = sum;
        word.flags.row_end = (int'(col_q) + 1 >= wid);
        word.flags.plane_end = word.flags.row_end && (int'(row_q) + 1 >= hgt);
        word.flags.image_end = word.flags.plane_end && (int'(plane_q) + 1 >= cnt);
        if (word.flags.row_end) begin
            col_q = '0;
            run_sum = '0;
            if (word.flags.plane_end) begin
                row_q = '0;
                plane_q = word.flags.image_end ? '0 : plane_q + 1'b1;
            end else begin
                row_q = row_q + 1'b1;
            end
        end else begin
            col_q = col_q + 1'b1;
        end
        return word;
    endfunction

    function automatic void check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
        end
    endfunction

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Driver: offers backlog words and predicts each one that is accepted.
    always @(posedge i_clk) begin
        if (push && !full) begin
            area_expect.push_back(integrate_pixel(i_pixel));
        end
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (!push || !full) begin
            if (pixel_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
                push <= 1'b1;
                i_pixel <= pixel_backlog.pop_front();
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Monitor: checks each accepted result word against the oldest prediction.
    always @(posedge i_clk) begin
        t_area_word expected;
        if (pop && !empty) begin
            if (area_expect.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected word, expected none, actual sum %0d", $time,
                         o_area_sum);
            end else begin
                expected = area_expect.pop_front();
                check_field("area_sum", expected.area_sum, o_area_sum);
                check_field("row_end", expected.flags.row_end, o_row_end);
                check_field("plane_end", expected.flags.plane_end, o_plane_end);
                check_field("image_end", expected.flags.image_end, o_image_end);
            end
        end
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_left > 0) begin
            pop <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_pending && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left <= HOLD_CYCLES;
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pixel_backlog.size() != 0 || push || area_expect.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (index)
            CFG_FRAME_WIDTH:  width_reg = value;
            CFG_FRAME_HEIGHT: height_reg = value;
            CFG_PLANE_COUNT:  planes_reg = value[PLANE_CNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_pressure(int phase);
        case (phase % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 47; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 47; end
            default: begin idle_pct = 27; stall_pct = 27; end
        endcase
    endtask

    task automatic queue_pixels(int count, int mode);
        for (int k = 0; k < count; k++) begin
            case (mode)
                1: pixel_backlog.push_back(8'hFF);
                2: pixel_backlog.push_back(8'h00);
                3: pixel_backlog.push_back($urandom_range(1) ? 8'hFF : 8'h00);
                default: pixel_backlog.push_back(PIX_W'($urandom_range(255)));
            endcase
        end
    endtask

    function automatic int pick_width();
        int r;
        r = $urandom_range(99);
        if (r < 70) return $urandom_range(1, 8);
        if (r < 80) return $urandom_range(9, 40);
        if (r < 88) return $urandom_range(1025, 2047);
        if (r < 95) return 0;
        return $urandom_range(1000, 1024);
    endfunction

    function automatic int pick_height();
        int r;
        r = $urandom_range(99);
        if (r < 75) return $urandom_range(1, 4);
        if (r < 85) return 0;
        if (r < 92) return $urandom_range(1025, 2047);
        return $urandom_range(5, 30);
    endfunction

    // Mid-plane width growth may only reach columns already held in the line store.
    function automatic int safe_width(int value);
        int prefix;
        if (row_q == 0) return value;
        prefix = 0;
        while (prefix < LINE_DEPTH && line_valid[prefix]) prefix++;
        return (clamp_to(value, LINE_DEPTH) > prefix) ? prefix : value;
    endfunction

    initial begin
        int phase;
        int random_words;
        int count;
        phase = 0;
        random_words = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // One small image of full-scale pixels, every register written.
        write_reg(CFG_FRAME_WIDTH, 11'd2);
        write_reg(CFG_FRAME_HEIGHT, 11'd2);
        write_reg(CFG_PLANE_COUNT, 11'd1);
        queue_pixels(4, 1);
        wait_drained();

        // Zero width acts as one and a plane count above four acts as four.
        write_reg(CFG_FRAME_WIDTH, 11'd0);
        write_reg(CFG_PLANE_COUNT, 11'd7);
        pixel_backlog.push_back(8'h00);
        pixel_backlog.push_back(8'hFF);
        queue_pixels(6, 3);
        wait_drained();

        // Height beyond its range, then cut below the current row mid-plane.
        write_reg(CFG_FRAME_HEIGHT, 11'd2047);
        write_reg(CFG_PLANE_COUNT, 11'd1);
        queue_pixels(3, 0);
        wait_drained();
        write_reg(CFG_FRAME_HEIGHT, 11'd1);
        queue_pixels(1, 0);
        wait_drained();

        // Width cut while the column counter stands past the new bound.
        write_reg(CFG_FRAME_WIDTH, 11'd6);
        write_reg(CFG_FRAME_HEIGHT, 11'd2);
        queue_pixels(4, 0);
        wait_drained();
        write_reg(CFG_FRAME_WIDTH, 11'd2);
        queue_pixels(3, 0);
        wait_drained();

        // One full-width row fills the line store while the receiver holds off.
        write_reg(CFG_FRAME_WIDTH, 11'd2047);
        write_reg(CFG_FRAME_HEIGHT, 11'd1);
        hold_pending = 1'b1;
        queue_pixels(LINE_DEPTH, 0);
        wait_drained();

        while (random_words < RANDOM_WORDS) begin
            if ($urandom_range(3) == 0) begin
                wait_drained();
                if ($urandom_range(1)) begin
                    write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(safe_width(pick_width())));
                end
                if ($urandom_range(1)) begin
                    write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(pick_height()));
                end
                if ($urandom_range(1)) begin
                    write_reg(CFG_PLANE_COUNT, CFG_DATA_W'($urandom_range(7)));
                end
            end
            set_pressure(phase);
            phase++;
            count = $urandom_range(1, 80);
            queue_pixels(count, ($urandom_range(9) < 7) ? 0 : $urandom_range(1, 3));
            random_words += count;
            do @(negedge i_clk);
            while (pixel_backlog.size() != 0);
        end

        wait_drained();
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
